/* design/bofs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bofs_pkg
// Types, codes and helpers shared by the bar order fill simulator.
// ----------------------------------------------------------------------------
package bofs_pkg;

  localparam int PriceW = 48;
  localparam int DivW   = 47;
  localparam int TickW  = 16;
  localparam int QtyW   = 16;
  localparam int SlipW  = 24;

  localparam logic [63:0] TickReset = 64'd100;
  localparam logic [63:0] MaxReset  = 64'd10000000000000;

  typedef enum logic [3:0] {
    StFilled    = 4'd0,
    StNoFill    = 4'd1,
    StTime      = 4'd2,
    StInstr     = 4'd3,
    StVolume    = 4'd4,
    StBarPrice  = 4'd5,
    StOhlc      = 4'd6,
    StTick      = 4'd7,
    StQty       = 4'd8,
    StExecPrice = 4'd9,
    StType      = 4'd10
  } status_e;

  typedef enum logic [1:0] {
    CmdMarket  = 2'd0,
    CmdLimit   = 2'd1,
    CmdStop    = 2'd2,
    CmdUnknown = 2'd3
  } cmd_e;

  localparam logic SideBuy = 1'b0;

  localparam logic RegTick = 1'b0;

  typedef struct packed {
    status_e          status;
    logic             neg;
    logic             side;
    logic [QtyW-1:0]  qty;
  } tag_t;

  function automatic logic plausible(logic signed [PriceW-1:0] p, logic [DivW-1:0] lim);
    logic [PriceW-1:0] mag;
    mag = p[PriceW-1] ? PriceW'(-p) : PriceW'(p);
    return mag < {1'b0, lim};
  endfunction

endpackage

/* design/bofs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bofs_div
// Pipelined restoring divider, one quotient bit per stage, with tag.
// ----------------------------------------------------------------------------
module bofs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [bofs_pkg::DivW-1:0]   dvd_i,
  input  logic [bofs_pkg::TickW-1:0]  dsr_i,
  input  bofs_pkg::tag_t              tag_i,
  output logic                        valid_o,
  output logic [bofs_pkg::DivW-1:0]   quo_o,
  output logic [bofs_pkg::TickW-1:0]  rem_o,
  output bofs_pkg::tag_t              tag_o
);
  import bofs_pkg::*;

  logic              vld_q [DivW];
  logic [DivW-1:0]   dvd_q [DivW];
  logic [DivW-1:0]   quo_q [DivW];
  logic [TickW-1:0]  rem_q [DivW];
  tag_t              tag_q [DivW];

  for (genvar k = 0; k < DivW; k++) begin : g_stg
    logic             v_in;
    logic [DivW-1:0]  dvd_in;
    logic [DivW-1:0]  quo_in;
    logic [TickW-1:0] rem_in;
    tag_t             tag_in;
    logic [TickW:0]   trial;
    logic [TickW:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign dvd_in = dvd_i;
      assign quo_in = '0;
      assign rem_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = vld_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign quo_in = quo_q[k-1];
      assign rem_in = rem_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    assign trial = {rem_in, dvd_in[DivW-1]};
    assign ge    = trial >= {1'b0, dsr_i};
    assign diff  = trial - {1'b0, dsr_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[k] <= {dvd_in[DivW-2:0], 1'b0};
        quo_q[k] <= {quo_in[DivW-2:0], ge};
        rem_q[k] <= ge ? diff[TickW-1:0] : trial[TickW-1:0];
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[DivW-1];
  assign quo_o   = quo_q[DivW-1];
  assign rem_o   = rem_q[DivW-1];
  assign tag_o   = tag_q[DivW-1];

endmodule

/* design/bar_order_fill_simulator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_order_fill_simulator_core
// Validates an OHLC bar, decides an order fill and rounds it to the tick grid.
// ----------------------------------------------------------------------------
// Stages: input register, bar checks, order type decision, execution checks,
//   the bit-per-stage tick divider, rounding, scale back and output register.
// Throughput: one item per cycle; the whole pipeline holds when the output
//   stalls.
// Reset: async, active low; clears valid bits, tick = 100,
//   price limit = 10^13.
module bar_order_fill_simulator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // side, quantity, order_price, slip_ticks, bar_open, bar_high, bar_low,
  // bar_close, bar_time, instrument, bar_volume; zero pad to 432
  input  logic [431:0]  s_axis_tdata,
  // command
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // price, fill_side, fill_quantity; zero pad to 72
  output logic [71:0]   m_axis_tdata,
  // status
  output logic [3:0]    m_axis_tuser,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import bofs_pkg::*;

  logic [TickW-1:0] tick_q;
  logic [DivW-1:0]  max_q;
  logic             adv;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == RegTick) ? {48'd0, tick_q} : {17'd0, max_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= TickReset[TickW-1:0];
      max_q  <= MaxReset[DivW-1:0];
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3] == RegTick) begin
        tick_q <= pwdata[TickW-1:0];
      end else begin
        max_q <= pwdata[DivW-1:0];
      end
    end
  end

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // stage 0: input register
  logic                     v0_q;
  cmd_e                     cmd0_q;
  logic                     side0_q;
  logic [QtyW-1:0]          qty0_q;
  logic signed [PriceW-1:0] lvl0_q, o0_q, h0_q, l0_q, c0_q;
  logic [7:0]               slip0_q;
  logic [63:0]              time0_q, vol0_q;
  logic [31:0]              instr0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd0_q   <= cmd_e'(s_axis_tuser);
      side0_q  <= s_axis_tdata[0];
      qty0_q   <= s_axis_tdata[16:1];
      lvl0_q   <= s_axis_tdata[64:17];
      slip0_q  <= s_axis_tdata[72:65];
      o0_q     <= s_axis_tdata[120:73];
      h0_q     <= s_axis_tdata[168:121];
      l0_q     <= s_axis_tdata[216:169];
      c0_q     <= s_axis_tdata[264:217];
      time0_q  <= s_axis_tdata[328:265];
      instr0_q <= s_axis_tdata[360:329];
      vol0_q   <= s_axis_tdata[424:361];
    end
  end

  // stage 1: bar checks, slippage
  status_e st1_d;
  logic    v1_q;
  status_e st1_q;
  cmd_e    cmd1_q;
  logic    side1_q;
  logic [QtyW-1:0]          qty1_q;
  logic signed [PriceW-1:0] lvl1_q, o1_q, h1_q, l1_q;
  logic [SlipW-1:0]         slip1_q;

  always_comb begin
    priority if (time0_q == 64'd0 || time0_q[63]) begin
      st1_d = StTime;
    end else if (instr0_q == 32'd0) begin
      st1_d = StInstr;
    end else if (vol0_q[63]) begin
      st1_d = StVolume;
    end else if (!plausible(o0_q, max_q) || !plausible(h0_q, max_q) ||
                 !plausible(l0_q, max_q) || !plausible(c0_q, max_q)) begin
      st1_d = StBarPrice;
    end else if (l0_q > o0_q || l0_q > c0_q || h0_q < o0_q || h0_q < c0_q ||
                 l0_q > h0_q) begin
      st1_d = StOhlc;
    end else begin
      st1_d = StFilled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st1_q   <= st1_d;
      cmd1_q  <= cmd0_q;
      side1_q <= side0_q;
      qty1_q  <= qty0_q;
      lvl1_q  <= lvl0_q;
      o1_q    <= o0_q;
      h1_q    <= h0_q;
      l1_q    <= l0_q;
      slip1_q <= slip0_q * tick_q;
    end
  end

  // stage 2: order type decision
  status_e               st2_d;
  logic signed [PriceW:0] px2_d;
  logic signed [PriceW:0] o_x, lvl_x, slip_x;
  logic    v2_q;
  status_e st2_q;
  logic    side2_q;
  logic [QtyW-1:0]        qty2_q;
  logic signed [PriceW:0] px2_q;

  assign o_x    = {o1_q[PriceW-1], o1_q};
  assign lvl_x  = {lvl1_q[PriceW-1], lvl1_q};
  assign slip_x = {{(PriceW+1-SlipW){1'b0}}, slip1_q};

  always_comb begin
    st2_d = StFilled;
    px2_d = o_x;
    unique case (cmd1_q)
      CmdMarket: begin
        px2_d = (side1_q == SideBuy) ? o_x + slip_x : o_x - slip_x;
      end
      CmdLimit: begin
        if (side1_q == SideBuy) begin
          if (l1_q > lvl1_q) st2_d = StNoFill;
          px2_d = (o1_q <= lvl1_q) ? o_x : lvl_x;
        end else begin
          if (h1_q < lvl1_q) st2_d = StNoFill;
          px2_d = (o1_q >= lvl1_q) ? o_x : lvl_x;
        end
      end
      CmdStop: begin
        if (side1_q == SideBuy) begin
          if (h1_q < lvl1_q) st2_d = StNoFill;
          px2_d = ((o1_q >= lvl1_q) ? o_x : lvl_x) + slip_x;
        end else begin
          if (l1_q > lvl1_q) st2_d = StNoFill;
          px2_d = ((o1_q <= lvl1_q) ? o_x : lvl_x) - slip_x;
        end
      end
      default: st2_d = StType;
    endcase
    if (st1_q != StFilled) st2_d = st1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st2_q   <= st2_d;
      side2_q <= side1_q;
      qty2_q  <= qty1_q;
      px2_q   <= px2_d;
    end
  end

  // stage 3: quantity, execution price, tick checks
  status_e          st3_d;
  logic [PriceW:0]  mag3;
  logic             v3_q;
  tag_t             tag3_q;
  logic [DivW-1:0]  mag3_q;

  assign mag3 = px2_q[PriceW] ? (PriceW+1)'(-px2_q) : (PriceW+1)'(px2_q);

  always_comb begin
    priority if (st2_q != StFilled) begin
      st3_d = st2_q;
    end else if (qty2_q == '0) begin
      st3_d = StQty;
    end else if (!(mag3 < {2'b00, max_q})) begin
      st3_d = StExecPrice;
    end else if (tick_q == '0) begin
      st3_d = StTick;
    end else begin
      st3_d = StFilled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag3_q <= '{status: st3_d, neg: px2_q[PriceW], side: side2_q, qty: qty2_q};
      mag3_q <= mag3[DivW-1:0];
    end
  end

  // divider
  logic             vd;
  logic [DivW-1:0]  quo;
  logic [TickW-1:0] rem;
  tag_t             tagd;

  bofs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .dvd_i   (mag3_q),
    .dsr_i   (tick_q),
    .tag_i   (tag3_q),
    .valid_o (vd),
    .quo_o   (quo),
    .rem_o   (rem),
    .tag_o   (tagd)
  );

  // round half away from zero
  logic            inc;
  logic            vr_q;
  tag_t            tagr_q;
  logic [DivW:0]   qr_q;

  assign inc = {rem, 1'b0} >= {1'b0, tick_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (adv) begin
      vr_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tagr_q <= tagd;
      qr_q   <= {1'b0, quo} + {{DivW{1'b0}}, inc};
    end
  end

  // scale back by tick
  logic        vm_q;
  tag_t        tagm_q;
  logic [63:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (adv) begin
      vm_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tagm_q <= tagr_q;
      prod_q <= qr_q * tick_q;
    end
  end

  // output register
  status_e           sto_d;
  logic              ovf;
  logic [PriceW-1:0] price_d;
  logic              vo_q;
  status_e           sto_q;
  logic [PriceW-1:0] price_q;
  logic              side_q;
  logic [QtyW-1:0]   qty_q;

  assign ovf = tagm_q.neg ? (prod_q > 64'h0000_8000_0000_0000)
                          : (prod_q[63:PriceW-1] != '0);
  assign sto_d   = (tagm_q.status == StFilled && ovf) ? StExecPrice : tagm_q.status;
  assign price_d = tagm_q.neg ? PriceW'(-prod_q[PriceW-1:0]) : prod_q[PriceW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv) begin
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sto_q   <= sto_d;
      price_q <= (sto_d == StFilled) ? price_d : '0;
      side_q  <= (sto_d == StFilled) ? tagm_q.side : 1'b0;
      qty_q   <= (sto_d == StFilled) ? tagm_q.qty : '0;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tuser  = sto_q;
  assign m_axis_tdata  = {7'd0, qty_q, side_q, price_q};

  a_nofill_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != StFilled |-> m_axis_tdata == '0)
    else $error("non-fill result carries payload");

  a_fill_qty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == StFilled |-> m_axis_tdata[64:49] != '0)
    else $error("fill with zero quantity");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(tagm_q) && $stable(vm_q))
    else $error("pipeline moved during stall");

endmodule
